[design/wlp_pkg.sv]
// Shared constants and types for the window latency percentile block.
`timescale 1ns / 1ps
package wlp_pkg;

    localparam int WINDOW_DEPTH = 256;
    localparam int LAT_W        = 24;
    localparam int ENTRY_W      = LAT_W + 2;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int SHARE_SCALE  = 10000;
    localparam int PCT_SCALE    = 100;
    localparam int DIVD_W       = $clog2(SHARE_SCALE * WINDOW_DEPTH + 1);
    localparam int DIVS_W       = $clog2(((WINDOW_DEPTH > PCT_SCALE) ?
                                           WINDOW_DEPTH : PCT_SCALE) + 1);
    localparam int STEP_W       = $clog2(DIVD_W + 1);

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSTART,
        S_DIV,
        S_DDONE,
        S_LOAD,
        S_LOADW,
        S_SCAN,
        S_CHECK
    } t_state;

    typedef enum logic [1:0] {
        D_K95,
        D_K99,
        D_OK,
        D_STALL
    } t_dsel;

endpackage

[design/window_latency_percentiles.sv]
// Top level: sample ring with rank-by-count percentile search and shared divider.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | i_valid / o_ready  | command, latency, flags, sample_time
//   output   | o_valid / i_ready  | median, p95, p99, shares, count, last time
//
// A push is one RAM write. A query with n samples runs two serial divisions
// for the p95 and p99 ranks, then a rank search (each candidate scans the
// whole window through the single RAM read port), then two divisions for the
// shares. An empty window answers in the cycle after the query is taken.
// Reset clears pointer, fill count and time; the RAM is never cleared.
// A result waits in the output register; pushes are still taken meanwhile.
`timescale 1ns / 1ps
module window_latency_percentiles
    import wlp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_command,
    input  logic [23:0]  i_latency,
    input  logic         i_sample_ok,
    input  logic         i_sample_stalled,
    input  logic [31:0]  i_sample_time,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [24:0]  o_median_half,
    output logic [23:0]  o_p95_latency,
    output logic [23:0]  o_p99_latency,
    output logic [13:0]  o_success_share,
    output logic [13:0]  o_stall_share,
    output logic [8:0]   o_sample_count,
    output logic [31:0]  o_last_time
);

    t_state              r_state, n_state;
    t_dsel               r_dsel;
    logic [ADDR_W-1:0]   r_wp;
    logic [CNT_W-1:0]    r_fill;
    logic [31:0]         r_time;
    logic [CNT_W-1:0]    r_i, r_j, r_lt, r_le, r_okc, r_stc, r_k95, r_k99;
    logic                r_dv;
    logic [LAT_W-1:0]    r_cand, r_med_a, r_med_b, r_p95, r_p99;
    logic [DIVD_W-1:0]   r_dq;
    logic [DIVS_W-1:0]   r_dvs, r_rem;
    logic [STEP_W-1:0]   r_dcnt;
    logic [13:0]         r_okshare;

    logic                w_in_acc, w_out_acc, w_push, w_issue;
    logic [ADDR_W-1:0]   w_raddr;
    logic [ENTRY_W-1:0]  w_rdata;
    logic [LAT_W-1:0]    w_rlat;
    logic [CNT_W-1:0]    w_ka, w_kb, w_nm1;
    logic [DIVS_W:0]     w_rem_sh;
    logic                w_qbit;
    logic [DIVD_W-1:0]   w_dividend;
    logic [DIVS_W-1:0]   w_divisor;

    assign w_in_acc  = i_valid && o_ready;
    assign w_out_acc = o_valid && i_ready;
    assign w_push    = w_in_acc && (i_command == CMD_PUSH);
    assign w_rlat    = w_rdata[LAT_W-1:0];
    assign w_nm1     = r_fill - CNT_W'(1);
    assign w_ka      = w_nm1 >> 1;
    assign w_kb      = r_fill >> 1;

    wlp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wp),
        .i_wdata ({i_sample_stalled, i_sample_ok, i_latency}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Control outputs: ready, read address, scan issue
    always_comb begin
        o_ready = (r_state == S_IDLE) && (!o_valid || (i_command == CMD_PUSH));
        w_issue = (r_state == S_SCAN) && (r_j < r_fill);
        w_raddr = (r_state == S_SCAN) ? r_j[ADDR_W-1:0] : r_i[ADDR_W-1:0];
    end

    // Divider operands and one restoring step
    always_comb begin
        unique case (r_dsel)
            D_K95:   w_dividend = DIVD_W'(95) * DIVD_W'(w_nm1) + DIVD_W'(50);
            D_K99:   w_dividend = DIVD_W'(99) * DIVD_W'(w_nm1) + DIVD_W'(50);
            D_OK:    w_dividend = DIVD_W'(SHARE_SCALE) * DIVD_W'(r_okc);
            default: w_dividend = DIVD_W'(SHARE_SCALE) * DIVD_W'(r_stc);
        endcase
        w_divisor = ((r_dsel == D_K95) || (r_dsel == D_K99)) ?
                    DIVS_W'(PCT_SCALE) : DIVS_W'(r_fill);
        w_rem_sh  = {r_rem, r_dq[DIVD_W-1]};
        w_qbit    = (w_rem_sh >= {1'b0, r_dvs});
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_command == CMD_QUERY) && (r_fill != '0)) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (r_dcnt == STEP_W'(1)) begin
                    n_state = S_DDONE;
                end
            end
            S_DDONE: begin
                unique case (r_dsel)
                    D_K95:   n_state = S_DSTART;
                    D_K99:   n_state = S_LOAD;
                    D_OK:    n_state = S_DSTART;
                    default: n_state = S_IDLE;
                endcase
            end
            S_LOAD:  n_state = S_LOADW;
            S_LOADW: n_state = S_SCAN;
            S_SCAN: begin
                if (!w_issue && !r_dv) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (r_i == w_nm1) ? S_DSTART : S_LOAD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wp    <= '0;
            r_fill  <= '0;
            r_time  <= '0;
            o_valid <= 1'b0;
            r_dsel  <= D_K95;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            // Advance the ring on a push
            if (w_push) begin
                r_wp   <= (r_wp == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : r_wp + ADDR_W'(1);
                if (r_fill != CNT_W'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + CNT_W'(1);
                end
                r_time <= i_sample_time;
            end
            // Drop the result once taken, raise it when a query finishes
            if (w_out_acc) begin
                o_valid <= 1'b0;
            end
            if (w_in_acc && (i_command == CMD_QUERY)) begin
                r_dsel <= D_K95;
                if (r_fill == '0) begin
                    o_valid <= 1'b1;
                end
            end
            if (r_state == S_DDONE) begin
                unique case (r_dsel)
                    D_K95:   r_dsel <= D_K99;
                    D_K99:   r_dsel <= D_OK;
                    D_OK:    r_dsel <= D_STALL;
                    default: o_valid <= 1'b1;
                endcase
            end
            r_dv <= w_issue;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        // Capture count and last time on every query; zero the result for an empty window
        if (w_in_acc && (i_command == CMD_QUERY)) begin
            o_last_time    <= r_time;
            o_sample_count <= 9'(r_fill);
            if (r_fill == '0) begin
                o_median_half   <= '0;
                o_p95_latency   <= '0;
                o_p99_latency   <= '0;
                o_success_share <= '0;
                o_stall_share   <= '0;
            end
        end
        unique case (r_state)
            S_DSTART: begin
                r_dq   <= w_dividend;
                r_dvs  <= w_divisor;
                r_rem  <= '0;
                r_dcnt <= STEP_W'(DIVD_W);
                r_i    <= '0;
            end
            S_DIV: begin
                r_rem  <= w_qbit ? DIVS_W'(w_rem_sh - {1'b0, r_dvs}) : DIVS_W'(w_rem_sh);
                r_dq   <= {r_dq[DIVD_W-2:0], w_qbit};
                r_dcnt <= r_dcnt - STEP_W'(1);
            end
            S_DDONE: begin
                unique case (r_dsel)
                    D_K95:   r_k95     <= CNT_W'(r_dq);
                    D_K99:   r_k99     <= CNT_W'(r_dq);
                    D_OK:    r_okshare <= 14'(r_dq);
                    default: begin
                        o_success_share <= r_okshare;
                        o_stall_share   <= 14'(r_dq);
                        o_median_half   <= 25'(r_med_a) + 25'(r_med_b);
                        o_p95_latency   <= r_p95;
                        o_p99_latency   <= r_p99;
                    end
                endcase
            end
            S_LOADW: begin
                r_cand <= w_rlat;
                r_j    <= '0;
                r_lt   <= '0;
                r_le   <= '0;
                if (r_i == '0) begin
                    r_okc <= '0;
                    r_stc <= '0;
                end
            end
            S_SCAN: begin
                if (w_issue) begin
                    r_j <= r_j + CNT_W'(1);
                end
                // Count entries below and not above the candidate
                if (r_dv) begin
                    if (w_rlat < r_cand) begin
                        r_lt <= r_lt + CNT_W'(1);
                    end
                    if (w_rlat <= r_cand) begin
                        r_le <= r_le + CNT_W'(1);
                    end
                    if (r_i == '0) begin
                        r_okc <= r_okc + CNT_W'(w_rdata[LAT_W]);
                        r_stc <= r_stc + CNT_W'(w_rdata[LAT_W+1]);
                    end
                end
            end
            S_CHECK: begin
                // Candidate holds every rank in [lt, le)
                if ((r_lt <= w_ka) && (w_ka < r_le)) r_med_a <= r_cand;
                if ((r_lt <= w_kb) && (w_kb < r_le)) r_med_b <= r_cand;
                if ((r_lt <= r_k95) && (r_k95 < r_le)) r_p95 <= r_cand;
                if ((r_lt <= r_k99) && (r_k99 < r_le)) r_p99 <= r_cand;
                r_i <= r_i + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count above window depth");
    a_rank_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_lt < r_le))
        else $error("candidate not counted against itself");
    a_push_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (r_fill != CNT_W'(WINDOW_DEPTH))) |=> (r_fill == $past(r_fill) + CNT_W'(1)))
        else $error("push did not grow the window");
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_command == CMD_QUERY) && (r_fill != '0)) |=> !o_valid)
        else $error("result raised before query finished");
`endif

endmodule

[design/wlp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module wlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
